@@ rtl/pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdt_pkg
// Types and constants shared by the persistent device tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

  localparam int ADDR_W  = 48;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int USED_W  = 7;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 32;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_MIN_SIGHTINGS = 2'd0;
  localparam cfg_index_t CFG_MIN_AGE_MS    = 2'd1;
  localparam cfg_index_t CFG_STALE_MS      = 2'd2;

  localparam logic OP_SIGHTING = 1'b0;
  localparam logic OP_PURGE    = 1'b1;

  localparam logic [COUNT_W-1:0] MIN_SIGHTINGS_RST = 16'd3;
  localparam logic [TIME_W-1:0]  MIN_AGE_MS_RST    = 32'd300000;
  localparam logic [TIME_W-1:0]  STALE_MS_RST      = 32'd1800000;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  first_seen;
    logic [TIME_W-1:0]  last_seen;
    logic [COUNT_W-1:0] count;
    logic               flagged;
  } pdt_entry_t;

  typedef struct packed {
    logic load_item;
    logic issue;
    logic hit_latch;
    logic update;
    logic append;
    logic purge;
    logic purge_finish;
    logic load_result;
  } pdt_cmd_t;

  typedef struct packed {
    logic hit;
    logic walk_done;
    logic out_free;
  } pdt_status_t;

endpackage

`default_nettype wire

@@ rtl/pdt_ram.sv @@
// ----------------------------------------------------------------------------
// pdt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdt_ctrl
// Sequencer that walks the table for a sighting or a purge transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic                op,
  input  wire pdt_pkg::pdt_status_t status,
  output pdt_pkg::pdt_cmd_t        cmd
);

  import pdt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_PURGE  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = (op == OP_PURGE) ? ST_PURGE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.hit) begin
          cmd.hit_latch = 1'b1;
          state_next    = ST_UPDATE;
        end else if (status.walk_done) begin
          cmd.append = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DONE;
      end
      ST_PURGE: begin
        cmd.issue = 1'b1;
        cmd.purge = 1'b1;
        if (status.walk_done) begin
          cmd.purge_finish = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pdt_datapath.sv @@
// ----------------------------------------------------------------------------
// pdt_datapath
// Table storage, walk counters, entry update logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [pdt_pkg::IN_W-1:0]    in_data,
  input  wire logic                        cfg_valid,
  input  wire pdt_pkg::cfg_index_t         cfg_index,
  input  wire logic [pdt_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [pdt_pkg::OUT_W-1:0]        out_data,
  input  wire pdt_pkg::pdt_cmd_t           cmd,
  output pdt_pkg::pdt_status_t             status
);

  import pdt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(pdt_entry_t);

  logic [COUNT_W-1:0] min_sightings;
  logic [TIME_W-1:0]  min_age_ms;
  logic [TIME_W-1:0]  stale_ms;

  logic [ADDR_W-1:0]  item_addr;
  logic [TIME_W-1:0]  item_now;

  logic [CW-1:0]      used_count;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      wr_idx;
  logic               cmp_vld;
  logic [IW-1:0]      cmp_idx;

  pdt_entry_t         hold_entry;
  logic [IW-1:0]      hold_idx;
  logic               became;
  logic               full;

  logic               res_became;
  logic               res_full;
  logic [USED_W-1:0]  res_used;

  pdt_entry_t         rd_entry;
  pdt_entry_t         upd_entry;
  pdt_entry_t         new_entry;
  pdt_entry_t         ram_wdata;
  logic [EW-1:0]      ram_rdata;
  logic [IW-1:0]      ram_waddr;
  logic               ram_we;

  logic               issue_ok;
  logic               room;
  logic               append_ok;
  logic               keep;
  logic [TIME_W-1:0]  stale_age;
  logic [TIME_W-1:0]  hit_age;
  logic [COUNT_W-1:0] count_inc;
  logic               flag_now;
  logic [CW+USED_W-1:0] used_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sightings <= MIN_SIGHTINGS_RST;
      min_age_ms    <= MIN_AGE_MS_RST;
      stale_ms      <= STALE_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_SIGHTINGS: min_sightings <= cfg_data[COUNT_W-1:0];
        CFG_MIN_AGE_MS:    min_age_ms    <= cfg_data;
        CFG_STALE_MS:      stale_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rd_entry  = pdt_entry_t'(ram_rdata);
  assign issue_ok  = cmd.issue && (rd_idx < used_count);
  assign room      = used_count < CW'(TABLE_DEPTH);
  assign append_ok = cmd.append && room;
  assign stale_age = item_now - rd_entry.last_seen;
  assign keep      = cmd.purge && cmp_vld && (stale_age < stale_ms);

  assign hit_age   = item_now - hold_entry.first_seen;
  assign count_inc = (hold_entry.count == COUNT_MAX) ? hold_entry.count
                                                     : hold_entry.count + 16'd1;
  assign flag_now  = !hold_entry.flagged && (count_inc >= min_sightings)
                     && (hit_age >= min_age_ms);

  always_comb begin
    upd_entry            = hold_entry;
    upd_entry.last_seen  = item_now;
    upd_entry.count      = count_inc;
    upd_entry.flagged    = hold_entry.flagged | flag_now;

    new_entry.addr       = item_addr;
    new_entry.first_seen = item_now;
    new_entry.last_seen  = item_now;
    new_entry.count      = 16'd1;
    new_entry.flagged    = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = hold_idx;
    ram_wdata = upd_entry;
    if (cmd.update) begin
      ram_we = 1'b1;
    end else if (append_ok) begin
      ram_we    = 1'b1;
      ram_waddr = used_count[IW-1:0];
      ram_wdata = new_entry;
    end else if (keep) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx[IW-1:0];
      ram_wdata = rd_entry;
    end
  end

  pdt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue_ok),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_addr <= in_data[ADDR_W-1:0];
      item_now  <= in_data[ADDR_W+TIME_W-1:ADDR_W];
    end
    cmp_idx <= rd_idx[IW-1:0];
    if (cmd.hit_latch) begin
      hold_entry <= rd_entry;
      hold_idx   <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      cmp_vld    <= 1'b0;
      became     <= 1'b0;
      full       <= 1'b0;
    end else begin
      cmp_vld <= issue_ok;
      if (cmd.load_item) begin
        rd_idx <= '0;
        wr_idx <= '0;
        became <= 1'b0;
        full   <= 1'b0;
      end else if (issue_ok) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (keep) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (cmd.update) begin
        became <= flag_now;
      end
      if (cmd.append) begin
        if (room) begin
          used_count <= used_count + 1'b1;
        end else begin
          full <= 1'b1;
        end
      end
      if (cmd.purge_finish) begin
        used_count <= wr_idx;
      end
    end
  end

  assign used_wide = {{USED_W{1'b0}}, used_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_became <= became;
      res_full   <= full;
      res_used   <= used_wide[USED_W-1:0];
    end
  end

  assign out_data = {{(OUT_W - USED_W - 2){1'b0}}, res_used, res_full, res_became};

  assign status.hit       = cmp_vld && (rd_entry.addr == item_addr);
  assign status.walk_done = !cmp_vld && !(rd_idx < used_count);
  assign status.out_free  = !out_valid || out_ready;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(TABLE_DEPTH))
    else $error("used count exceeds table depth");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    wr_idx <= rd_idx)
    else $error("purge write index passed read index");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    append_ok |=> used_count == $past(used_count) + 1'b1)
    else $error("append did not grow the table");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_became && res_full))
    else $error("result flags persistent and full together");

endmodule

`default_nettype wire

@@ rtl/persistent_device_tracker.sv @@
// ----------------------------------------------------------------------------
// persistent_device_tracker
// Tracks sightings of radio devices in a bounded table and flags devices
// that keep appearing; a purge transaction drops stale entries in order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: addr, now; tuser: op
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: became, full, used
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A transaction walks the valid entries through the single table read port,
// one entry per cycle. A hit stops the walk early, and an update state
// then writes the changed entry back to the table.
// Reset empties the table at once; entry contents need no clearing.
// The result sits in an output register; a stalled output holds the next
// transaction in its final state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module persistent_device_tracker #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [pdt_pkg::IN_W-1:0]  s_axis_tdata,  // device_addr[47:0], now_ms[79:48]
  input  wire logic                      s_axis_tuser,  // op[0]
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [pdt_pkg::OUT_W-1:0]      m_axis_tdata,  // became_persistent[0],
                                                        // table_full[1],
                                                        // entries_used[8:2]
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire pdt_pkg::cfg_index_t       cfg_index,
  input  wire logic [pdt_pkg::CFG_W-1:0] cfg_data
);

  import pdt_pkg::*;

  pdt_cmd_t    cmd;
  pdt_status_t status;

  assign cfg_ready = 1'b1;

  pdt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .op            (s_axis_tuser),
    .status        (status),
    .cmd           (cmd)
  );

  pdt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
